// ----- sv/p3rd_pkg.sv -----
package p3rd_pkg;

    // longest line in received bytes before a forced cut
    localparam int MAX_LINE = 8192;
    localparam int LEN_W    = $clog2(MAX_LINE + 1);

    // output buffer: two slots per beat worst case
    localparam int OBUF_DEPTH = 4;
    localparam int OPTR_W     = $clog2(OBUF_DEPTH);
    localparam int OCNT_W     = $clog2(OBUF_DEPTH + 1);

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;

    // input command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    typedef enum logic {
        PH_STATUS = 1'b0,
        PH_BODY   = 1'b1
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       in_body;
        logic       line_end;
        logic       response_done;
        logic [7:0] status_code;
        logic       conn_error;
        logic       last;
    } res_t;

endpackage

// ----- sv/pop3_response_deframer.sv -----
// POP3 response deframer.
// Input channel (s_valid/s_ready): one beat per received byte (s_cmd = 0,
// byte on s_data_in) or a connection-closed event (s_cmd = 1).
// Result channel (m_valid/m_ready): zero, one or two result beats per input
// beat, m_last set on the last one. A leading body dot (and a CR behind it)
// is held back and gives no beat until the next byte decides its fate.
// Configuration channel (cfg_valid/cfg_ready): writes multiline_expected;
// cfg_ready is always high. Write it only while the block is idle.
// Results are registered in the output buffer and offered from its head.
// Throughput: one input beat per cycle while s_ready is high. Each beat is
// decoded combinationally against the line state and written into a
// four-entry output buffer; s_ready is high while at least two buffer
// slots are free, so a beat that yields two results still fits.
// Reset (aresetn low, synchronous): line state, status code and the buffer
// are cleared; multiline_expected returns to 0.
// When the receiver stalls, results wait in the buffer and s_ready drops
// once fewer than two slots remain; nothing is lost or reordered.
module pop3_response_deframer
    import p3rd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [7:0] s_data_in,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_data_valid,
    output logic       m_in_body,
    output logic       m_line_end,
    output logic       m_response_done,
    output logic [7:0] m_status_code,
    output logic       m_conn_error,
    output logic       m_last
);

    logic             ml_reg;
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             pcr_reg, pcr_next;
    logic             dot_reg, dot_next;
    logic             hcr_reg, hcr_next;
    logic [7:0]       status_reg, status_next;

    res_t             obuf_reg [OBUF_DEPTH];
    logic [OPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OCNT_W-1:0] cnt_reg;

    logic             push, pop;
    res_t             r0, r1;
    logic [1:0]       n_res;

    // line counting for the current byte
    logic [LEN_W-1:0] len_inc;
    logic             cnt_end;
    logic [LEN_W-1:0] cnt_len;
    logic             cnt_pcr;

    assign cfg_ready = 1'b1;
    assign s_ready   = (cnt_reg <= OCNT_W'(OBUF_DEPTH - 2));
    assign push      = s_valid && s_ready;
    assign m_valid   = (cnt_reg != '0);
    assign pop       = m_valid && m_ready;

    assign len_inc = len_reg + 1'b1;
    assign cnt_end = (pcr_reg && s_data_in == CH_LF) || (len_inc >= LEN_W'(MAX_LINE));
    assign cnt_len = cnt_end ? '0 : len_inc;
    assign cnt_pcr = cnt_end ? 1'b0 : (s_data_in == CH_CR);

    // decode one beat against the line state
    always_comb begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        pcr_next    = pcr_reg;
        dot_next    = dot_reg;
        hcr_next    = hcr_reg;
        status_next = status_reg;
        r0          = '0;
        r1          = '0;
        n_res       = 2'd0;

        if (s_cmd == CMD_CLOSE) begin
            // drop everything, report the error
            phase_next    = PH_STATUS;
            len_next      = '0;
            pcr_next      = 1'b0;
            dot_next      = 1'b0;
            hcr_next      = 1'b0;
            status_next   = '0;
            r0.conn_error = 1'b1;
            n_res         = 2'd1;
        end else if (phase_reg == PH_STATUS) begin
            if (len_reg == '0) begin
                status_next = s_data_in;
            end
            len_next     = cnt_len;
            pcr_next     = cnt_pcr;
            r0.data_byte  = s_data_in;
            r0.data_valid = 1'b1;
            r0.line_end   = cnt_end;
            if (cnt_end && ml_reg && status_next == CH_PLUS) begin
                phase_next = PH_BODY;
            end else begin
                r0.response_done = cnt_end;
            end
            n_res = 2'd1;
        end else if (hcr_reg) begin
            hcr_next = 1'b0;
            dot_next = 1'b0;
            if (s_data_in == CH_LF) begin
                // dot CR LF terminator
                phase_next       = PH_STATUS;
                len_next         = '0;
                pcr_next         = 1'b0;
                r0.in_body       = 1'b1;
                r0.line_end      = 1'b1;
                r0.response_done = 1'b1;
                n_res            = 2'd1;
            end else begin
                // release the held CR, then this byte
                r0.data_byte  = CH_CR;
                r0.data_valid = 1'b1;
                r0.in_body    = 1'b1;
                len_next      = cnt_len;
                pcr_next      = cnt_pcr;
                r1.data_byte  = s_data_in;
                r1.data_valid = 1'b1;
                r1.in_body    = 1'b1;
                r1.line_end   = cnt_end;
                n_res         = 2'd2;
            end
        end else if (dot_reg) begin
            if (s_data_in == CH_CR) begin
                // hold the CR behind the dot
                len_next = len_inc;
                pcr_next = 1'b1;
                hcr_next = 1'b1;
            end else begin
                dot_next      = 1'b0;
                len_next      = cnt_len;
                pcr_next      = cnt_pcr;
                r0.data_byte  = s_data_in;
                r0.data_valid = 1'b1;
                r0.in_body    = 1'b1;
                r0.line_end   = cnt_end;
                n_res         = 2'd1;
            end
        end else if (len_reg == '0 && s_data_in == CH_DOT) begin
            // hold the leading dot
            len_next = LEN_W'(1);
            pcr_next = 1'b0;
            dot_next = 1'b1;
        end else begin
            len_next      = cnt_len;
            pcr_next      = cnt_pcr;
            r0.data_byte  = s_data_in;
            r0.data_valid = 1'b1;
            r0.in_body    = 1'b1;
            r0.line_end   = cnt_end;
            n_res         = 2'd1;
        end

        r0.status_code = status_next;
        r1.status_code = status_next;
        if (n_res == 2'd2) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
    end

    // hold line state, configuration and buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ml_reg     <= 1'b0;
            phase_reg  <= PH_STATUS;
            len_reg    <= '0;
            pcr_reg    <= 1'b0;
            dot_reg    <= 1'b0;
            hcr_reg    <= 1'b0;
            status_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                ml_reg <= cfg_data;
            end
            if (push) begin
                phase_reg  <= phase_next;
                len_reg    <= len_next;
                pcr_reg    <= pcr_next;
                dot_reg    <= dot_next;
                hcr_reg    <= hcr_next;
                status_reg <= status_next;
                wr_ptr_reg <= wr_ptr_reg + OPTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (push ? OCNT_W'(n_res) : '0) - OCNT_W'(pop);
        end
    end

    // write result beats into the output buffer
    always_ff @(posedge aclk) begin
        if (push && n_res != 2'd0) begin
            obuf_reg[wr_ptr_reg] <= r0;
            if (n_res == 2'd2) begin
                obuf_reg[wr_ptr_reg + 1'b1] <= r1;
            end
        end
    end

    assign m_data_byte     = obuf_reg[rd_ptr_reg].data_byte;
    assign m_data_valid    = obuf_reg[rd_ptr_reg].data_valid;
    assign m_in_body       = obuf_reg[rd_ptr_reg].in_body;
    assign m_line_end      = obuf_reg[rd_ptr_reg].line_end;
    assign m_response_done = obuf_reg[rd_ptr_reg].response_done;
    assign m_status_code   = obuf_reg[rd_ptr_reg].status_code;
    assign m_conn_error    = obuf_reg[rd_ptr_reg].conn_error;
    assign m_last          = obuf_reg[rd_ptr_reg].last;

endmodule
